// File: design/m2sci_pkg.sv
`timescale 1ns / 1ps

package m2sci_pkg;

  // Stream byte positions wrap at this width.
  localparam int unsigned POS_W = 40;

  localparam logic [23:0] RECENT_INIT = 24'hFF_FFFF;
  localparam logic [23:0] START_PREFIX = 24'h00_0001;

  // Start code values that follow the 00 00 01 prefix.
  localparam logic [7:0] SC_SEQUENCE = 8'hB3;
  localparam logic [7:0] SC_GROUP = 8'hB8;
  localparam logic [7:0] SC_PICTURE = 8'h00;

  // Header byte counts.
  localparam logic [2:0] SEQ_HDR_BYTES = 3'd4;
  localparam logic [2:0] PIC_HDR_BYTES = 3'd2;
  localparam logic [2:0] SKIP_LAST = 3'd7;

  // Event kinds.
  localparam logic [1:0] EV_SEQUENCE = 2'd0;
  localparam logic [1:0] EV_GROUP = 2'd1;
  localparam logic [1:0] EV_PICTURE = 2'd2;
  localparam logic [1:0] EV_BAD_PICTURE = 2'd3;

  // Legal picture coding types.
  localparam logic [2:0] PIC_I = 3'd1;
  localparam logic [2:0] PIC_B = 3'd3;

  typedef enum logic [4:0] {
    PH_SCAN = 5'b00001,
    PH_CODE = 5'b00010,
    PH_SEQ = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_PIC = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic [23:0] recent;
    logic [2:0] hcount;
    logic [31:0] hshift;
    logic seq_seen;
    logic grp_pend;
    logic [31:0] pic_count;
    logic [POS_W-1:0] byte_pos;
    logic [POS_W-1:0] code_pos;
  } parse_state_t;

  localparam parse_state_t PARSE_STATE_INIT = '{
    phase: PH_SCAN,
    recent: RECENT_INIT,
    hcount: 3'd0,
    hshift: 32'd0,
    seq_seen: 1'b0,
    grp_pend: 1'b0,
    pic_count: 32'd0,
    byte_pos: '0,
    code_pos: '0
  };

  typedef struct packed {
    logic [1:0] event_kind;
    logic [39:0] start_position;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [3:0] aspect_code;
    logic [15:0] rate_millihertz;
    logic fields_valid;
    logic [2:0] picture_kind;
    logic [9:0] temporal_reference;
    logic begins_group;
    logic [31:0] picture_number;
  } result_t;

  // Frame rate code to rate in millihertz; reserved codes give zero.
  function automatic logic [15:0] rate_lookup(input logic [3:0] code);
    logic [15:0] rate;
    unique case (code)
      4'd1: rate = 16'd23976;
      4'd2: rate = 16'd24000;
      4'd3: rate = 16'd25000;
      4'd4: rate = 16'd29970;
      4'd5: rate = 16'd30000;
      4'd6: rate = 16'd50000;
      4'd7: rate = 16'd59940;
      4'd8: rate = 16'd60000;
      default: rate = 16'd0;
    endcase
    return rate;
  endfunction

  // Round a 12-bit size up to a multiple of 16.
  function automatic logic [12:0] round16(input logic [11:0] size);
    logic [12:0] sum;
    sum = {1'b0, size} + 13'd15;
    return {sum[12:4], 4'b0000};
  endfunction

endpackage

// File: design/m2sci_in_if.sv
`timescale 1ns / 1ps

interface m2sci_in_if;
  import m2sci_pkg::*;

  logic valid;
  logic ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: design/m2sci_out_if.sv
`timescale 1ns / 1ps

interface m2sci_out_if;
  import m2sci_pkg::*;

  logic valid;
  logic ready;
  logic [1:0] event_kind;
  logic [39:0] start_position;
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [3:0] aspect_code;
  logic [15:0] rate_millihertz;
  logic fields_valid;
  logic [2:0] picture_kind;
  logic [9:0] temporal_reference;
  logic begins_group;
  logic [31:0] picture_number;

  modport source (
    output valid, output event_kind, output start_position, output frame_width,
    output frame_height, output aspect_code, output rate_millihertz,
    output fields_valid, output picture_kind, output temporal_reference,
    output begins_group, output picture_number, input ready
  );
  modport sink (
    input valid, input event_kind, input start_position, input frame_width,
    input frame_height, input aspect_code, input rate_millihertz,
    input fields_valid, input picture_kind, input temporal_reference,
    input begins_group, input picture_number, output ready
  );
endinterface

// File: design/m2sci_parse.sv
`timescale 1ns / 1ps

module m2sci_parse (
  input  m2sci_pkg::parse_state_t st,
  input  logic [7:0]              data_byte,
  output m2sci_pkg::parse_state_t st_nxt,
  output logic                    hit,
  output m2sci_pkg::result_t      res
);
  import m2sci_pkg::*;

  logic [31:0] shifted;
  logic [2:0] cnt_inc;
  logic [23:0] recent_new;
  logic [2:0] pic_kind;

  assign shifted = {st.hshift[23:0], data_byte};
  assign cnt_inc = st.hcount + 3'd1;
  assign recent_new = {st.recent[15:0], data_byte};
  assign pic_kind = shifted[5:3];

  always_comb begin
    st_nxt = st;
    st_nxt.byte_pos = st.byte_pos + POS_W'(1);
    hit = 1'b0;
    res = '0;
    res.start_position = 40'(st.code_pos);

    unique case (st.phase)
      PH_CODE: begin
        st_nxt.recent = RECENT_INIT;
        st_nxt.hcount = 3'd0;
        st_nxt.hshift = 32'd0;
        st_nxt.phase = PH_SCAN;
        if (data_byte == SC_SEQUENCE) begin
          st_nxt.grp_pend = 1'b1;
          if (st.seq_seen) begin
            // Repeat header: report now, skip its eight bytes
            st_nxt.phase = PH_SKIP;
            hit = 1'b1;
            res.event_kind = EV_SEQUENCE;
          end else begin
            st_nxt.seq_seen = 1'b1;
            st_nxt.phase = PH_SEQ;
          end
        end else if (data_byte == SC_GROUP) begin
          if (st.seq_seen && !st.grp_pend) begin
            st_nxt.grp_pend = 1'b1;
            hit = 1'b1;
            res.event_kind = EV_GROUP;
          end
        end else if (data_byte == SC_PICTURE) begin
          if (st.seq_seen) st_nxt.phase = PH_PIC;
        end
      end
      PH_SEQ: begin
        st_nxt.hshift = shifted;
        st_nxt.hcount = cnt_inc;
        if (cnt_inc == SEQ_HDR_BYTES) begin
          st_nxt.phase = PH_SKIP;
          hit = 1'b1;
          res.event_kind = EV_SEQUENCE;
          res.frame_width = round16(shifted[31:20]);
          res.frame_height = round16(shifted[19:8]);
          res.aspect_code = shifted[7:4];
          res.rate_millihertz = rate_lookup(shifted[3:0]);
          res.fields_valid = 1'b1;
        end
      end
      PH_SKIP: begin
        if (st.hcount == SKIP_LAST) begin
          st_nxt.hcount = 3'd0;
          st_nxt.phase = PH_SCAN;
        end else begin
          st_nxt.hcount = cnt_inc;
        end
      end
      PH_PIC: begin
        st_nxt.hshift = shifted;
        st_nxt.hcount = cnt_inc;
        if (cnt_inc == PIC_HDR_BYTES) begin
          st_nxt.hcount = 3'd0;
          st_nxt.phase = PH_SCAN;
          hit = 1'b1;
          res.picture_kind = pic_kind;
          res.temporal_reference = shifted[15:6];
          res.picture_number = st.pic_count;
          if (pic_kind < PIC_I || pic_kind > PIC_B) begin
            res.event_kind = EV_BAD_PICTURE;
          end else begin
            res.event_kind = EV_PICTURE;
            res.begins_group = st.grp_pend;
            st_nxt.grp_pend = 1'b0;
            st_nxt.pic_count = st.pic_count + 32'd1;
          end
        end
      end
      default: begin
        // Scan: look for the 00 00 01 prefix
        st_nxt.phase = PH_SCAN;
        st_nxt.recent = recent_new;
        if (recent_new == START_PREFIX) begin
          st_nxt.phase = PH_CODE;
          st_nxt.code_pos = st.byte_pos - POS_W'(2);
        end
      end
    endcase
  end

endmodule

// File: design/mpeg2_start_code_indexer_unit.sv
`timescale 1ns / 1ps
// Path: a result reaches the port once the byte that completes its event has
//   passed the input register and then the result register.
// Throughput: 1 byte per cycle unless a held result stalls, set by the parse
//   update, combinational between the registers; bytes without events vanish.
// Reset: synchronous, active-low rst_n clears both stages and the parse state.

module mpeg2_start_code_indexer_unit (
  input logic         clk,
  input logic         rst_n,
  m2sci_in_if.sink    in_stream,
  m2sci_out_if.source out_event
);
  import m2sci_pkg::*;

  // Input register stage
  logic s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // Parse state and result register
  parse_state_t st_r, st_nxt;
  logic out_valid_r, out_valid_nxt;
  result_t out_r;

  logic hit;
  result_t res;
  logic advance;
  logic in_fire;
  logic s1_fire;

  // The input stage moves on whenever the result register is empty or drained.
  assign advance = !out_valid_r || out_event.ready;
  assign in_stream.ready = !s1_valid_r || advance;
  assign in_fire = in_stream.valid && in_stream.ready;
  assign s1_fire = s1_valid_r && advance;

  m2sci_parse u_parse (
    .st        (st_r),
    .data_byte (s1_byte_r),
    .st_nxt    (st_nxt),
    .hit       (hit),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = s1_valid_r && hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r <= PARSE_STATE_INIT;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // Advance the parse state only as the byte leaves the input stage
      if (s1_fire) st_r <= st_nxt;
    end
  end

  // Payload: capture the byte and the result, hold them otherwise
  always_ff @(posedge clk) begin
    if (in_fire) s1_byte_r <= in_stream.data_byte;
    if (s1_fire && hit) out_r <= res;
  end

  assign out_event.valid = out_valid_r;
  assign out_event.event_kind = out_r.event_kind;
  assign out_event.start_position = out_r.start_position;
  assign out_event.frame_width = out_r.frame_width;
  assign out_event.frame_height = out_r.frame_height;
  assign out_event.aspect_code = out_r.aspect_code;
  assign out_event.rate_millihertz = out_r.rate_millihertz;
  assign out_event.fields_valid = out_r.fields_valid;
  assign out_event.picture_kind = out_r.picture_kind;
  assign out_event.temporal_reference = out_r.temporal_reference;
  assign out_event.begins_group = out_r.begins_group;
  assign out_event.picture_number = out_r.picture_number;

endmodule

// File: design/m2sci_checker.sv
`timescale 1ns / 1ps

module m2sci_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [39:0] start_position,
  input logic [12:0] frame_width,
  input logic [12:0] frame_height,
  input logic        fields_valid,
  input logic        begins_group
);
  import m2sci_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(start_position))
    else $error("result changed while stalled");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with result path free");

  a_fields_only_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fields_valid |-> event_kind == EV_SEQUENCE)
    else $error("sequence fields on non-sequence event");

  a_size_rounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fields_valid |-> frame_width[3:0] == 4'd0 &&
      frame_height[3:0] == 4'd0)
    else $error("frame size not a multiple of 16");

  a_group_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && begins_group |-> event_kind == EV_PICTURE)
    else $error("group flag on non-picture event");

endmodule

bind mpeg2_start_code_indexer_unit m2sci_checker u_m2sci_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_stream.ready),
  .out_valid      (out_event.valid),
  .out_ready      (out_event.ready),
  .event_kind     (out_event.event_kind),
  .start_position (out_event.start_position),
  .frame_width    (out_event.frame_width),
  .frame_height   (out_event.frame_height),
  .fields_valid   (out_event.fields_valid),
  .begins_group   (out_event.begins_group)
);
